[hw/rtl/dmhq_pkg.sv]
// Shared types and constants of the min-heap scheduler queue.
package dmhq_pkg;

  localparam int unsigned ID_W     = 8;
  localparam int unsigned STAMP_W  = 48;
  localparam int unsigned KEY_W    = 49;
  localparam int unsigned BURN_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OCC_W    = 7;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // operations
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  // key ordering modes
  localparam logic MODE_FIFO = 1'b0;
  localparam logic MODE_EDF  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ORDER_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BURNOUT_TIME = 2'd1;

  typedef struct packed {
    logic               op;
    logic [ID_W-1:0]    requester_id;
    logic [STAMP_W-1:0] request_stamp;
    logic [STAMP_W-1:0] last_service_stamp;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     popped_id;
    logic [KEY_W-1:0]    popped_key;
    logic [OCC_W-1:0]    occupancy;
  } out_item_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [KEY_W-1:0] key;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic set_full;
    logic set_empty;
    logic ins_init;
    logic rd_parent;
    logic up_move;
    logic write_cur;
    logic pop_read;
    logic pop_take;
    logic rd_children;
    logic dn_move;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic op;
    logic full;
    logic empty;
    logic last_one;
    logic at_root;
    logic up_less;
    logic dn_move;
  } dp_stat_t;

endpackage

[hw/rtl/deadline_or_fifo_min_heap_queue.sv]
// Top level of the deadline-or-fifo binary min-heap scheduler queue.
// One item is worked at a time: start is taken while busy is low, and
// the result is on result_o when done_o is high for exactly one cycle;
// it cannot be held off. Each heap level takes one read of the
// heap RAM and one compare and write on its single write port. The
// levels an entry can move number at most floor of log2(CAPACITY) on
// an insert and one less on a pop. A full insert or an empty pop ends
// in the dispatch state. busy drops the cycle done_o rises, so the
// next item may be started then. The key is fixed at insert: the
// request stamp in fifo mode, last service stamp plus burnout time in
// deadline mode. Change order_mode only while the queue is empty. The
// configuration channel is always ready and should be written while
// idle.
module deadline_or_fifo_min_heap_queue #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  dmhq_pkg::in_item_t              item_i,
  output logic                            done_o,
  output dmhq_pkg::out_item_t             result_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [dmhq_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [dmhq_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import dmhq_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  dmhq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .done_o  (done_o),
    .stat_i  (stat),
    .cmd_o   (cmd)
  );

  dmhq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .result_o    (result_o)
  );

endmodule

[hw/rtl/dmhq_ctrl.sv]
// Sequencer for insert sift-up and pop sift-down of the heap queue.
module dmhq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  output logic              done_o,
  input  dmhq_pkg::dp_stat_t stat_i,
  output dmhq_pkg::dp_cmd_t  cmd_o
);
  import dmhq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_UP_CHECK,
    S_UP_CMP,
    S_POP_TAKE,
    S_DN_READ,
    S_DN_CMP
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    done_d  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat_i.op == OP_INSERT) begin
          if (stat_i.full) begin
            cmd_o.set_full = 1'b1;
            done_d          = 1'b1;
            state_d         = S_IDLE;
          end else begin
            cmd_o.ins_init = 1'b1;
            state_d        = S_UP_CHECK;
          end
        end else begin
          if (stat_i.empty) begin
            cmd_o.set_empty = 1'b1;
            done_d          = 1'b1;
            state_d         = S_IDLE;
          end else begin
            cmd_o.pop_read = 1'b1;
            state_d        = S_POP_TAKE;
          end
        end
      end
      S_UP_CHECK: begin
        if (stat_i.at_root) begin
          cmd_o.write_cur = 1'b1;
          done_d          = 1'b1;
          state_d         = S_IDLE;
        end else begin
          cmd_o.rd_parent = 1'b1;
          state_d         = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (stat_i.up_less) begin
          cmd_o.up_move = 1'b1;
          state_d       = S_UP_CHECK;
        end else begin
          cmd_o.write_cur = 1'b1;
          done_d          = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_POP_TAKE: begin
        cmd_o.pop_take = 1'b1;
        if (stat_i.last_one) begin
          // queue drains: nothing left to move
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_DN_READ;
        end
      end
      S_DN_READ: begin
        cmd_o.rd_children = 1'b1;
        state_d           = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (stat_i.dn_move) begin
          cmd_o.dn_move = 1'b1;
          state_d       = S_DN_READ;
        end else begin
          cmd_o.write_cur = 1'b1;
          done_d          = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

`ifndef SYNTHESIS
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe held longer than one cycle");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == S_IDLE))
    else $error("result strobe while an item is still in work");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && state_q == S_IDLE) |=> (state_q == S_DISPATCH) && !done_q)
    else $error("accepted item did not start");
`endif

endmodule

[hw/rtl/dmhq_dp.sv]
// Heap store, configuration registers, key formation and sift datapath.
module dmhq_dp #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  dmhq_pkg::in_item_t               item_i,
  input  logic                             cfg_we_i,
  input  logic [dmhq_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [dmhq_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  dmhq_pkg::dp_cmd_t                cmd_i,
  output dmhq_pkg::dp_stat_t               stat_o,
  output dmhq_pkg::out_item_t              result_o
);
  import dmhq_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = AW + 2;  // child index incl. overflow room

  // configuration
  logic              mode_q;
  logic [BURN_W-1:0] burnout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_FIFO;
      burnout_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ORDER_MODE:   mode_q    <= cfg_data_i[0];
        CFG_BURNOUT_TIME: burnout_q <= cfg_data_i[BURN_W-1:0];
        default: ;
      endcase
    end
  end

  // control state
  logic          op_q;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] pos_q, pos_d;

  // payload
  entry_t              cur_q, cur_d;
  logic [STATUS_W-1:0] status_q, status_d;
  entry_t              popped_q, popped_d;

  // store
  entry_t        mem_q [CAPACITY];
  entry_t        rdata_a_q, rdata_b_q;
  logic [AW-1:0] raddr_a, raddr_b;
  logic          we;
  entry_t        wdata;

  logic [AW-1:0] parent_idx;
  logic [XW-1:0] lc_idx, rc_idx;
  logic          lc_ok, rc_ok, take_l, take_r;
  logic [KEY_W-1:0] l_or_cur_key;
  logic [KEY_W-1:0] new_key;

  assign parent_idx = (pos_q - AW'(1)) >> 1;
  assign lc_idx     = {1'b0, pos_q, 1'b1};
  assign rc_idx     = lc_idx + XW'(1);
  assign lc_ok      = lc_idx < XW'(count_q);
  assign rc_ok      = rc_idx < XW'(count_q);
  assign take_l       = lc_ok && (rdata_a_q.key < cur_q.key);
  assign l_or_cur_key = take_l ? rdata_a_q.key : cur_q.key;
  assign take_r       = rc_ok && (rdata_b_q.key < l_or_cur_key);

  assign new_key = (mode_q == MODE_EDF)
                 ? (KEY_W'(item_i.last_service_stamp) + KEY_W'(burnout_q))
                 : KEY_W'(item_i.request_stamp);

  // read addresses
  always_comb begin
    raddr_a = '0;
    raddr_b = '0;
    if (cmd_i.rd_parent) begin
      raddr_a = parent_idx;
    end else if (cmd_i.pop_read) begin
      raddr_b = AW'(count_q - CW'(1));
    end else if (cmd_i.rd_children) begin
      raddr_a = lc_idx[AW-1:0];
      raddr_b = rc_idx[AW-1:0];
    end
  end

  // write port: the moving entry stays in cur_q until its slot is found
  always_comb begin
    we    = cmd_i.write_cur | cmd_i.up_move | cmd_i.dn_move;
    wdata = cur_q;
    if (cmd_i.up_move) begin
      wdata = rdata_a_q;
    end else if (cmd_i.dn_move) begin
      wdata = take_r ? rdata_b_q : rdata_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[pos_q] <= wdata;
    end
    rdata_a_q <= mem_q[raddr_a];
    rdata_b_q <= mem_q[raddr_b];
  end

  always_comb begin
    count_d  = count_q;
    pos_d    = pos_q;
    cur_d    = cur_q;
    status_d = status_q;
    popped_d = popped_q;
    if (cmd_i.load) begin
      cur_d.id  = item_i.requester_id;
      cur_d.key = new_key;
      status_d  = STATUS_OK;
      popped_d  = '0;
    end
    if (cmd_i.set_full) begin
      status_d = STATUS_FULL;
    end
    if (cmd_i.set_empty) begin
      status_d = STATUS_EMPTY;
    end
    if (cmd_i.ins_init) begin
      pos_d   = count_q[AW-1:0];
      count_d = count_q + CW'(1);
    end
    if (cmd_i.up_move) begin
      pos_d = parent_idx;
    end
    if (cmd_i.pop_take) begin
      popped_d = rdata_a_q;
      cur_d    = rdata_b_q;
      count_d  = count_q - CW'(1);
      pos_d    = '0;
    end
    if (cmd_i.dn_move) begin
      pos_d = take_r ? rc_idx[AW-1:0] : lc_idx[AW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q    <= OP_INSERT;
      count_q <= '0;
      pos_q   <= '0;
    end else begin
      if (cmd_i.load) begin
        op_q <= item_i.op;
      end
      count_q <= count_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    status_q <= status_d;
    popped_q <= popped_d;
  end

  assign stat_o.op       = op_q;
  assign stat_o.full     = (count_q == CW'(CAPACITY));
  assign stat_o.empty    = (count_q == '0);
  assign stat_o.last_one = (count_q == CW'(1));
  assign stat_o.at_root  = (pos_q == '0);
  assign stat_o.up_less  = (cur_q.key < rdata_a_q.key);
  assign stat_o.dn_move  = take_l | take_r;

  assign result_o.status     = status_q;
  assign result_o.popped_id  = popped_q.id;
  assign result_o.popped_key = popped_q.key;
  assign result_o.occupancy  = OCC_W'(count_q);

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_insert_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ins_init |-> (count_q < CW'(CAPACITY)))
    else $error("insert started on a full heap");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.pop_read || cmd_i.pop_take) |-> (count_q != '0))
    else $error("pop started on an empty heap");

  a_write_in_heap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (CW'(pos_q) < count_q))
    else $error("heap write outside occupied slots");
`endif

endmodule
